@@ hw/rtl/bftr_pkg.sv @@
// ----------------------------------------------------------------------------
// bftr_pkg
// Shared types and constants of the bitmap font text renderer.
// ----------------------------------------------------------------------------
package bftr_pkg;

  localparam int unsigned STORE_WORDS_DEF = 2048;
  localparam int unsigned MAX_ROWS_DEF    = 16;
  localparam int unsigned GLYPH_COUNT_DEF = 95;

  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd126;
  localparam logic [7:0] FULL_ROW   = 8'hFF;

  localparam logic [1:0] OP_DRAW      = 2'd0;
  localparam logic [1:0] OP_ROW_WRITE = 2'd1;
  localparam logic [1:0] OP_WIDTH_WR  = 2'd2;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_HEIGHT   = 2'd2;
  localparam logic [1:0] CFG_STRIDE   = 2'd3;

  // Width of a value taken to the address reduction unit: glyph index times
  // stride, or a raw store address.
  localparam int unsigned RED_W = 13;

  typedef struct packed {
    logic             start;
    logic [RED_W-1:0] value;
  } bftr_red_cmd_t;

endpackage

@@ hw/rtl/bftr_ram.sv @@
// ----------------------------------------------------------------------------
// bftr_ram
// Single write port, single registered read port storage array.
// ----------------------------------------------------------------------------
module bftr_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bftr_addr_red.sv @@
// ----------------------------------------------------------------------------
// bftr_addr_red
// Reciprocal-multiply unit reducing a value modulo the store depth.
// ----------------------------------------------------------------------------
module bftr_addr_red
  import bftr_pkg::*;
#(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEF,
  localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bftr_red_cmd_t cmd_i,
  output logic          done_o,
  output logic [AW-1:0] result_o
);

  localparam int unsigned SH    = RED_W + $clog2(STORE_WORDS);
  localparam int unsigned RECIP = ((32'd1 << SH) + STORE_WORDS - 1) / STORE_WORDS;
  localparam int unsigned MW    = RED_W + 2;
  localparam int unsigned PW    = RED_W + MW;
  localparam int unsigned SB    = $clog2(STORE_WORDS + 1);
  localparam int unsigned RW    = RED_W + SB;

  logic [RED_W-1:0] val_q, val_d;
  logic [RED_W-1:0] quot_q, quot_d;
  logic [RED_W-1:0] acc_q, acc_d;
  logic             step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [PW-1:0]    prod;
  logic [RW-1:0]    diff;

  assign prod = PW'(val_q) * PW'(RECIP);
  assign diff = RW'(val_q) - RW'(quot_q) * RW'(STORE_WORDS);

  always_comb begin
    val_d  = val_q;
    quot_d = quot_q;
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (cmd_i.start) begin
      val_d  = cmd_i.value;
      step_d = 1'b0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!step_q) begin
        quot_d = RED_W'(prod >> SH);
        step_d = 1'b1;
      end else begin
        acc_d  = RED_W'(diff);
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    quot_q <= quot_d;
    acc_q  <= acc_d;
  end

  assign done_o   = done_q;
  assign result_o = AW'(acc_q);

endmodule

@@ hw/rtl/bitmap_font_text_renderer.sv @@
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer
// Proportional 1-bit font renderer emitting one masked glyph row per result.
// ----------------------------------------------------------------------------
// A width write, and a draw of a code that prints nothing, are completed in
// the idle state. A glyph row write and a printable draw pass the store
// address through a shared reciprocal-multiply unit that reduces it modulo
// the store depth in three steps; a draw then reads one row a cycle from the
// glyph store through its single read port while the output keeps up, and
// none with height zero. The block takes no request until the last row has
// left for the output register.
module bitmap_font_text_renderer
  import bftr_pkg::*;
#(
  parameter int unsigned STORE_WORDS = STORE_WORDS_DEF,
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // char_code[7:0], string_start[8], store_address[19:9], row_bits[27:20],
  // width_value[31:28]
  input  logic [31:0] s_axis_tdata_i,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // pixel_x[15:0], pixel_y[31:16], pixel_mask[39:32]
  output logic [39:0] m_axis_tdata_o,
  // last_row
  output logic        m_axis_tlast_o
);

  localparam int unsigned AW  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int unsigned IW  = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RED   = 3'd1;
  localparam logic [2:0] ST_ROWS  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;

  logic [2:0]  state_q, state_d;

  logic signed [15:0] origin_x_q, origin_y_q;
  logic [4:0]  height_q, stride_q;

  logic [7:0]  in_code;
  logic        in_start;
  logic [10:0] in_addr;
  logic [7:0]  in_bits;
  logic [3:0]  in_wval;
  logic [1:0]  in_op;

  logic        accept;
  logic        printable;
  logic [6:0]  idx7;

  logic [15:0] cursor_q, cursor_d;
  logic        op_wr_q, op_wr_d;
  logic [7:0]  bits_q, bits_d;
  logic [3:0]  w_q, w_d;
  logic [7:0]  mask_q, mask_d;
  logic [RCW-1:0] rows_q, rows_d, r_q, r_d, rows_cfg;
  logic [AW-1:0]  addr_q, addr_d;

  logic        pend_q, pend_d;
  logic [RCW-1:0] pend_row_q, pend_row_d;
  logic        pend_move;

  logic        out_valid_q, out_valid_d;
  logic [15:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [7:0]  out_mask_q, out_mask_d;
  logic        out_last_q, out_last_d;

  bftr_red_cmd_t red_cmd;
  logic          red_done;
  logic [AW-1:0] red_result;

  logic          gm_we, gm_re;
  logic [AW-1:0] gm_waddr;
  logic [7:0]    gm_rdata;

  logic          wt_we, wt_re;
  logic [IW-1:0] wt_addr;
  logic [3:0]    wt_rdata;

  assign in_code  = s_axis_tdata_i[7:0];
  assign in_start = s_axis_tdata_i[8];
  assign in_addr  = s_axis_tdata_i[19:9];
  assign in_bits  = s_axis_tdata_i[27:20];
  assign in_wval  = s_axis_tdata_i[31:28];
  assign in_op    = s_axis_tuser_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign idx7      = 7'(in_code - CODE_FIRST);
  assign printable = (in_code >= CODE_FIRST) && (in_code <= CODE_LAST)
                     && (32'(idx7) < GLYPH_COUNT);

  assign rows_cfg  = (32'(height_q) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(height_q);
  assign pend_move = pend_q && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      height_q   <= 5'd8;
      stride_q   <= 5'd8;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        CFG_HEIGHT:   height_q   <= cfg_data_i[4:0];
        CFG_STRIDE:   stride_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    op_wr_d     = op_wr_q;
    bits_d      = bits_q;
    w_d         = w_q;
    mask_d      = mask_q;
    rows_d      = rows_q;
    r_d         = r_q;
    addr_d      = addr_q;
    pend_d      = pend_q;
    pend_row_d  = pend_row_q;
    red_cmd     = '0;
    gm_we       = 1'b0;
    gm_re       = 1'b0;
    gm_waddr    = red_result;
    wt_we       = 1'b0;
    wt_re       = 1'b0;
    wt_addr     = IW'(idx7);

    if (pend_move) begin
      pend_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_ROW_WRITE: begin
              red_cmd.start = 1'b1;
              red_cmd.value = RED_W'(in_addr);
              bits_d        = in_bits;
              op_wr_d       = 1'b1;
              state_d       = ST_RED;
            end
            OP_WIDTH_WR: begin
              wt_we = printable;
            end
            OP_DRAW: begin
              if (in_start) begin
                cursor_d = origin_x_q;
              end
              if (printable) begin
                wt_re         = 1'b1;
                red_cmd.start = 1'b1;
                red_cmd.value = RED_W'(idx7) * RED_W'(stride_q);
                op_wr_d       = 1'b0;
                state_d       = ST_RED;
              end else begin
                cursor_d = (in_start ? origin_x_q : cursor_q) + 16'd1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RED: begin
        if (red_done) begin
          if (op_wr_q) begin
            gm_we   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            w_d    = wt_rdata;
            mask_d = ~(FULL_ROW >> wt_rdata);
            rows_d = rows_cfg;
            r_d    = '0;
            addr_d = red_result;
            if (rows_cfg == '0) begin
              cursor_d = cursor_q + 16'(wt_rdata) + 16'd1;
              state_d  = ST_IDLE;
            end else begin
              state_d = ST_ROWS;
            end
          end
        end
      end
      ST_ROWS: begin
        if (!pend_q || pend_move) begin
          gm_re      = 1'b1;
          pend_d     = 1'b1;
          pend_row_d = r_q;
          r_d        = r_q + 1'b1;
          addr_d     = (addr_q == AW'(STORE_WORDS - 1)) ? '0 : addr_q + 1'b1;
          if (r_q == rows_q - 1'b1) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!pend_q || pend_move) begin
          cursor_d = cursor_q + 16'(w_q) + 16'd1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_mask_d  = out_mask_q;
    out_last_d  = out_last_q;
    if (pend_move) begin
      out_valid_d = 1'b1;
      out_x_d     = cursor_q;
      out_y_d     = origin_y_q + 16'(pend_row_q);
      out_mask_d  = gm_rdata & mask_q;
      out_last_d  = (pend_row_q == rows_q - 1'b1);
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '0;
      op_wr_q     <= 1'b0;
      rows_q      <= '0;
      r_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      op_wr_q     <= op_wr_d;
      rows_q      <= rows_d;
      r_q         <= r_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q     <= bits_d;
    w_q        <= w_d;
    mask_q     <= mask_d;
    addr_q     <= addr_d;
    pend_row_q <= pend_row_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_mask_q <= out_mask_d;
    out_last_q <= out_last_d;
  end

  bftr_addr_red #(
    .STORE_WORDS(STORE_WORDS)
  ) u_addr_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (red_cmd),
    .done_o  (red_done),
    .result_o(red_result)
  );

  bftr_ram #(
    .DEPTH(STORE_WORDS),
    .WIDTH(8)
  ) u_glyph_rows (
    .clk_i  (clk_i),
    .we_i   (gm_we),
    .waddr_i(gm_waddr),
    .wdata_i(bits_q),
    .re_i   (gm_re),
    .raddr_i(addr_q),
    .rdata_o(gm_rdata)
  );

  bftr_ram #(
    .DEPTH(GLYPH_COUNT),
    .WIDTH(4)
  ) u_glyph_widths (
    .clk_i  (clk_i),
    .we_i   (wt_we),
    .waddr_i(wt_addr),
    .wdata_i(in_wval),
    .re_i   (wt_re),
    .raddr_i(wt_addr),
    .rdata_o(wt_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_mask_q, out_y_q, out_x_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
